// File: rtl/rrtt_pkg.sv
// shared types and constants of the round-robin task table
package rrtt_pkg;

   localparam int MAX_TASKS = 16;
   localparam int ID_BITS   = 16;
   localparam int IDX_BITS  = $clog2(MAX_TASKS);
   localparam int CNT_BITS  = $clog2(MAX_TASKS + 1);

   localparam logic [2:0] OP_ADD    = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_PICK   = 3'd2;
   localparam logic [2:0] OP_TICK   = 3'd3;
   localparam logic [2:0] OP_LOOKUP = 3'd4;
   localparam logic [2:0] OP_EXIT   = 3'd5;
   localparam logic [2:0] OP_SLEEP  = 3'd6;
   localparam logic [2:0] OP_WAIT   = 3'd7;

   localparam logic [2:0] TS_RUNNING  = 3'd0;
   localparam logic [2:0] TS_IDLE     = 3'd1;
   localparam logic [2:0] TS_STOPPED  = 3'd2;
   localparam logic [2:0] TS_RUNNABLE = 3'd3;
   localparam logic [2:0] TS_SLEEP    = 3'd4;
   localparam logic [2:0] TS_WAITING  = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;

   localparam logic [4:0] KIDS_MAX = 5'd31;

   typedef struct packed {
      logic [2:0]         operation;
      logic [15:0]        task_id;
      logic [15:0]        other_id;
      logic [15:0]        sleep_ticks;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] result_id;
      logic [2:0]  result_state;
      logic [4:0]  result_children;
   } rsp_type;

   typedef struct packed {
      logic [ID_BITS-1:0] id;
      logic [2:0]         state;
      logic [15:0]        sleep;
      logic [ID_BITS-1:0] parent;
      logic [ID_BITS-1:0] await_id;
      logic [4:0]         kids;
   } slot_type;

   // datapath actions chosen by the controller
   typedef enum logic [3:0] {
      DP_NONE,
      DP_LOAD,      // latch request, clear scan index
      DP_IDX_INC,   // step scan index
      DP_IDX_ZERO,  // restart scan at slot 0
      DP_KEEP_S,    // remember scan index as subject slot
      DP_KEEP_P,    // remember scan index as parent slot
      DP_TICK,      // tick slot at scan index
      DP_SHIFT,     // copy slot idx+1 into idx
      DP_APPEND,    // write new slot at end, bump count
      DP_DROP,      // decrement count
      DP_PAR_INC,   // parent kids up
      DP_EXIT_UPD,  // parent kids down, maybe wake
      DP_SET_SLEEP,
      DP_SET_WAIT,
      DP_SEEK_PAR   // subject's parent becomes search key
   } dp_op_type;

   typedef enum logic [2:0] {
      RS_SLOT_S,    // report subject slot
      RS_SLOT_P,    // report parent slot
      RS_SLOT_IDX,  // report slot at scan index
      RS_FAIL,
      RS_FULLT,
      RS_OKZERO,
      RS_REMOVED
   } rsp_sel_type;

   typedef struct packed {
      dp_op_type   op;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } cmd_type;

   typedef struct packed {
      logic [2:0] operation;
      logic       key_zero;     // search key is zero
      logic       idx_last;     // scan index is the last valid slot or beyond
      logic       idx_valid;    // scan index below entry count
      logic       hit;          // slot at index matches key
      logic       runnable;     // slot at index is runnable
      logic       is_s;         // index equals subject slot
      logic       s_found;
      logic       full;
      logic       empty;
      logic       par_zero;     // subject's parent id is zero
   } stat_type;

endpackage

// File: rtl/rrtt_datapath.sv
// task table storage, scan index and response register
module rrtt_datapath (
   input  logic             clock,
   input  logic             reset,
   input  rrtt_pkg::req_type req_word,
   input  rrtt_pkg::cmd_type cmd,
   output rrtt_pkg::stat_type stat,
   output rrtt_pkg::rsp_type rsp_word
);
   import rrtt_pkg::*;

   slot_type            table_ff [MAX_TASKS];
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] idx_ff;
   logic [IDX_BITS-1:0] s_ff, p_ff;
   logic                s_found_ff;
   logic [ID_BITS-1:0]  key_ff;
   req_type             req_ff;
   rsp_type             rsp_ff;

   logic [IDX_BITS-1:0] ix, ix1, cnt_ix;
   slot_type            cur, nxt, s_slot, p_slot;

   assign ix     = idx_ff[IDX_BITS-1:0];
   assign ix1    = ix + IDX_BITS'(1);
   assign cnt_ix = count_ff[IDX_BITS-1:0];
   assign cur    = table_ff[ix];
   assign nxt    = table_ff[ix1];
   assign s_slot = table_ff[s_ff];
   assign p_slot = table_ff[p_ff];

   always_comb begin
      stat.operation = req_ff.operation;
      stat.key_zero  = (key_ff == '0);
      stat.idx_valid = (idx_ff < count_ff);
      stat.idx_last  = ({1'b0, idx_ff} + (CNT_BITS + 1)'(1) >= {1'b0, count_ff});
      stat.hit       = (cur.id == key_ff);
      stat.runnable  = (cur.state == TS_RUNNABLE);
      stat.is_s      = s_found_ff && (ix == s_ff);
      stat.s_found   = s_found_ff;
      stat.full      = (count_ff == CNT_BITS'(MAX_TASKS));
      stat.empty     = (count_ff == '0);
      stat.par_zero  = (s_slot.parent == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         idx_ff     <= '0;
         s_found_ff <= 1'b0;
      end else begin
         case (cmd.op)
            DP_LOAD: begin
               req_ff     <= req_word;
               key_ff     <= (req_word.operation == OP_ADD) ? req_word.other_id
                                                            : req_word.task_id;
               idx_ff     <= '0;
               s_found_ff <= 1'b0;
            end
            DP_IDX_INC:  idx_ff <= idx_ff + CNT_BITS'(1);
            DP_IDX_ZERO: idx_ff <= '0;
            DP_KEEP_S: begin
               s_ff       <= ix;
               s_found_ff <= 1'b1;
            end
            DP_KEEP_P:   p_ff <= ix;
            DP_SEEK_PAR: begin
               key_ff <= s_slot.parent;
               idx_ff <= '0;
            end
            DP_TICK: begin
               if (cur.state == TS_SLEEP) begin
                  if (cur.sleep == '0) table_ff[ix].state <= TS_RUNNABLE;
                  else table_ff[ix].sleep <= cur.sleep - 16'd1;
               end
               idx_ff <= idx_ff + CNT_BITS'(1);
            end
            DP_SHIFT: begin
               table_ff[ix] <= nxt;
               idx_ff       <= idx_ff + CNT_BITS'(1);
            end
            DP_PAR_INC: begin
               if (p_slot.kids < KIDS_MAX) table_ff[p_ff].kids <= p_slot.kids + 5'd1;
            end
            DP_APPEND: begin
               table_ff[cnt_ix] <= '{id: req_ff.task_id, state: TS_RUNNABLE,
                                     sleep: '0, parent: req_ff.other_id,
                                     await_id: '0, kids: '0};
               s_ff     <= cnt_ix;
               count_ff <= count_ff + CNT_BITS'(1);
            end
            DP_DROP: count_ff <= count_ff - CNT_BITS'(1);
            DP_EXIT_UPD: begin
               if (p_slot.kids != '0) table_ff[p_ff].kids <= p_slot.kids - 5'd1;
               if (p_slot.state == TS_WAITING && p_slot.await_id == s_slot.id)
                  table_ff[p_ff].state <= TS_RUNNABLE;
            end
            DP_SET_SLEEP: begin
               table_ff[s_ff].state <= TS_SLEEP;
               table_ff[s_ff].sleep <= req_ff.sleep_ticks;
            end
            DP_SET_WAIT: begin
               table_ff[s_ff].state    <= TS_WAITING;
               table_ff[s_ff].await_id <= req_ff.other_id;
            end
            default: ;
         endcase
      end
   end

   // response register, loaded as the controller finishes a word
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         unique case (cmd.rsp_sel)
            RS_SLOT_S:   rsp_ff <= '{ST_OK, s_slot.id, s_slot.state, s_slot.kids};
            RS_SLOT_P:   rsp_ff <= '{ST_OK, p_slot.id, p_slot.state, p_slot.kids};
            RS_SLOT_IDX: rsp_ff <= '{ST_OK, cur.id, cur.state, cur.kids};
            RS_FULLT:    rsp_ff <= '{ST_FULL, '0, '0, '0};
            RS_OKZERO:   rsp_ff <= '{ST_OK, '0, '0, '0};
            RS_REMOVED:  rsp_ff <= '{ST_OK, req_ff.task_id, TS_STOPPED, s_slot.kids};
            default:     rsp_ff <= '{ST_NONE, '0, '0, '0};
         endcase
      end
   end

   assign rsp_word = rsp_ff;
endmodule

// File: rtl/rrtt_control.sv
// sequencer that walks the table for each operation
module rrtt_control (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  rrtt_pkg::stat_type stat,
   output rrtt_pkg::cmd_type  cmd
);
   import rrtt_pkg::*;

   typedef enum logic [3:0] {
      IDLE, DISPATCH, FIND_S, FIND_P, PAR_INC, APPEND, SHIFT, EXIT_UPD,
      PICK_AFTER, PICK_WRAP, TICK, SET, DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      cmd          = '{op: DP_NONE, rsp_load: 1'b0, rsp_sel: RS_FAIL};
      req_ready    = 1'b0;
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      unique case (state_ff)
         IDLE: begin
            req_ready = !rsp_valid_ff || rsp_ready;
            if (req_valid && req_ready) begin
               cmd.op   = DP_LOAD;
               state_in = DISPATCH;
            end
         end
         DISPATCH: begin
            case (stat.operation)
               OP_ADD: begin
                  if (stat.full) begin
                     cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_FULLT; state_in = DONE;
                  end else if (stat.key_zero) state_in = APPEND;
                  else state_in = FIND_P;
               end
               OP_TICK: state_in = TICK;
               OP_PICK: begin
                  if (stat.empty) begin
                     cmd.rsp_load = 1'b1; state_in = DONE;
                  end else if (stat.key_zero) begin
                     cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_SLOT_IDX; state_in = DONE;
                  end else state_in = FIND_S;
               end
               default: state_in = FIND_S;
            endcase
         end
         FIND_S: begin
            if (!stat.idx_valid) begin
               if (stat.operation == OP_PICK) begin
                  cmd.op = DP_IDX_ZERO; state_in = PICK_WRAP;
               end else begin
                  cmd.rsp_load = 1'b1; state_in = DONE;
               end
            end else if (stat.hit) begin
               cmd.op = DP_KEEP_S;
               state_in = SET;
            end else cmd.op = DP_IDX_INC;
         end
         SET: begin
            case (stat.operation)
               OP_REMOVE: begin
                  cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_REMOVED; state_in = SHIFT;
               end
               OP_PICK: begin
                  cmd.op = DP_IDX_INC; state_in = PICK_AFTER;
               end
               OP_LOOKUP: begin
                  cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_SLOT_S; state_in = DONE;
               end
               OP_EXIT: begin
                  if (stat.par_zero) begin
                     cmd.rsp_load = 1'b1; state_in = DONE;
                  end else begin
                     cmd.op = DP_SEEK_PAR; state_in = FIND_P;
                  end
               end
               OP_SLEEP: begin
                  cmd.op = DP_SET_SLEEP; state_in = DONE;
               end
               default: begin
                  cmd.op = DP_SET_WAIT; state_in = DONE;
               end
            endcase
            if (stat.operation == OP_SLEEP || stat.operation == OP_WAIT) begin
               // report next cycle once the write has landed
               state_in = EXIT_UPD;
            end
         end
         FIND_P: begin
            if (!stat.idx_valid) begin
               if (stat.operation == OP_ADD) state_in = APPEND;
               else begin
                  cmd.rsp_load = 1'b1; state_in = DONE;
               end
            end else if (stat.hit) begin
               cmd.op = DP_KEEP_P;
               state_in = (stat.operation == OP_ADD) ? PAR_INC : EXIT_UPD;
            end else cmd.op = DP_IDX_INC;
         end
         PAR_INC: begin
            cmd.op = DP_PAR_INC; state_in = APPEND;
         end
         APPEND: begin
            cmd.op = DP_APPEND; state_in = EXIT_UPD;
         end
         EXIT_UPD: begin
            // final report of a written slot, or the parent update for an exit
            if (stat.operation == OP_EXIT) begin
               cmd.op = DP_EXIT_UPD; state_in = TICK;
            end else begin
               cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_SLOT_S; state_in = DONE;
            end
         end
         SHIFT: begin
            if (stat.idx_last) begin
               cmd.op = DP_DROP; state_in = DONE;
            end else cmd.op = DP_SHIFT;
         end
         PICK_AFTER: begin
            if (!stat.idx_valid) begin
               cmd.op = DP_IDX_ZERO; state_in = PICK_WRAP;
            end else if (stat.runnable) begin
               cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_SLOT_IDX; state_in = DONE;
            end else cmd.op = DP_IDX_INC;
         end
         PICK_WRAP: begin
            if (!stat.idx_valid) begin
               cmd.rsp_load = 1'b1; state_in = DONE;
            end else if (stat.runnable && !stat.is_s) begin
               cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_SLOT_IDX; state_in = DONE;
            end else cmd.op = DP_IDX_INC;
         end
         TICK: begin
            // exit reports parent after its update; tick walks all slots
            if (stat.operation == OP_EXIT) begin
               cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_SLOT_P; state_in = DONE;
            end else if (!stat.idx_valid) begin
               cmd.rsp_load = 1'b1; cmd.rsp_sel = RS_OKZERO; state_in = DONE;
            end else cmd.op = DP_TICK;
         end
         DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = IDLE;
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// File: rtl/round_robin_task_table_unit.sv
// top level of the round-robin task table
// Each word runs one operation on an ordered table of up to MAX_TASKS tasks. A sequencer
// walks the slots one per cycle from a single register table, so the work of an operation
// grows with the slots it visits. One word is in work at a time; the next is taken no
// earlier than the cycle in which the previous response leaves the output register.
module round_robin_task_table_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rrtt_pkg::req_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rrtt_pkg::rsp_type rsp_word
);
   import rrtt_pkg::*;

   stat_type stat;
   cmd_type  cmd;

   rrtt_control u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .stat, .cmd
   );

   rrtt_datapath u_dp (
      .clock, .reset, .req_word, .cmd, .stat, .rsp_word
   );

   // response fields stay in range
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.status != 2'd3)
      else $error("bad status");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("response changed while stalled");

   // table never overflows
   assert property (@(posedge clock) disable iff (reset)
      stat.full |-> !(cmd.op == DP_APPEND))
      else $error("append into full table");
endmodule

// File: verif/tb_top.sv
// testbench for the round-robin task table: random and directed operations checked by a scoreboard
import rrtt_pkg::*;

class task_table_board;
   logic [15:0] ids [MAX_TASKS];
   logic [2:0]  states [MAX_TASKS];
   logic [15:0] naps [MAX_TASKS];
   logic [15:0] parents [MAX_TASKS];
   logic [15:0] awaits [MAX_TASKS];
   logic [4:0]  kids [MAX_TASKS];
   int          used;
   rsp_type     pending[$];
   int          errors;
   int          checked;

   function new();
      used = 0;
      errors = 0;
      checked = 0;
   endfunction

   function int locate(logic [15:0] key);
      for (int i = 0; i < used; i++) begin
         if (ids[i] == key) return i;
      end
      return -1;
   endfunction

   function rsp_type slot_word(int s);
      rsp_type r;
      r.status = ST_OK;
      r.result_id = ids[s];
      r.result_state = states[s];
      r.result_children = kids[s];
      return r;
   endfunction

   // work out the response of one accepted word and update the table copy
   function void note_word(req_type w);
      rsp_type r;
      int s;
      int p;
      r = '0;
      r.status = ST_NONE;
      case (w.operation)
         OP_ADD: begin
            if (used >= MAX_TASKS) begin
               r.status = ST_FULL;
            end else begin
               p = locate(w.other_id);
               if (w.other_id != 0 && p >= 0 && kids[p] != KIDS_MAX) kids[p]++;
               ids[used] = w.task_id;
               states[used] = TS_RUNNABLE;
               naps[used] = '0;
               parents[used] = w.other_id;
               awaits[used] = '0;
               kids[used] = '0;
               used++;
               r = slot_word(used - 1);
            end
         end
         OP_REMOVE: begin
            s = locate(w.task_id);
            if (s >= 0) begin
               r.status = ST_OK;
               r.result_id = w.task_id;
               r.result_state = TS_STOPPED;
               r.result_children = kids[s];
               for (int i = s; i + 1 < used; i++) begin
                  ids[i] = ids[i+1];
                  states[i] = states[i+1];
                  naps[i] = naps[i+1];
                  parents[i] = parents[i+1];
                  awaits[i] = awaits[i+1];
                  kids[i] = kids[i+1];
               end
               used--;
            end
         end
         OP_PICK: begin
            if (used > 0) begin
               if (w.task_id == 0) begin
                  r = slot_word(0);
               end else begin
                  s = locate(w.task_id);
                  p = -1;
                  if (s >= 0) begin
                     for (int i = s + 1; i < used && p < 0; i++)
                        if (states[i] == TS_RUNNABLE) p = i;
                  end
                  for (int i = 0; i < used && p < 0; i++)
                     if (i != s && states[i] == TS_RUNNABLE) p = i;
                  if (p >= 0) r = slot_word(p);
               end
            end
         end
         OP_TICK: begin
            r.status = ST_OK;
            for (int i = 0; i < used; i++) begin
               if (states[i] == TS_SLEEP) begin
                  if (naps[i] == 0) states[i] = TS_RUNNABLE;
                  else naps[i]--;
               end
            end
         end
         OP_LOOKUP: begin
            s = locate(w.task_id);
            if (s >= 0) r = slot_word(s);
         end
         OP_EXIT: begin
            s = locate(w.task_id);
            if (s >= 0 && parents[s] != 0) begin
               p = locate(parents[s]);
               if (p >= 0) begin
                  if (kids[p] != 0) kids[p]--;
                  if (states[p] == TS_WAITING && awaits[p] == ids[s])
                     states[p] = TS_RUNNABLE;
                  r = slot_word(p);
               end
            end
         end
         OP_SLEEP: begin
            s = locate(w.task_id);
            if (s >= 0) begin
               states[s] = TS_SLEEP;
               naps[s] = w.sleep_ticks;
               r = slot_word(s);
            end
         end
         default: begin
            s = locate(w.task_id);
            if (s >= 0) begin
               states[s] = TS_WAITING;
               awaits[s] = w.other_id;
               r = slot_word(s);
            end
         end
      endcase
      pending.push_back(r);
   endfunction

   task report(string what);
      errors++;
      $display("mismatch: %s", what);
   endtask

   task check_word(rsp_type got);
      rsp_type want;
      checked++;
      if (pending.size() == 0) begin
         report($sformatf("unexpected word %h", got));
         return;
      end
      want = pending.pop_front();
      if (got.status != want.status)
         report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.result_id != want.result_id)
         report($sformatf("id got %h want %h", got.result_id, want.result_id));
      if (got.result_state != want.result_state)
         report($sformatf("state got %0d want %0d", got.result_state, want.result_state));
      if (got.result_children != want.result_children)
         report($sformatf("children got %0d want %0d", got.result_children,
                          want.result_children));
   endtask
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 0;
   logic    reset = 1;
   logic    req_valid = 0;
   logic    req_ready;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_ready = 0;
   rsp_type rsp_word;

   int send_idle = 32;
   int take_idle = 67;
   int cycles = 0;
   int sent = 0;
   int op_seen [8];
   task_table_board board = new();

   localparam int CYCLE_LIMIT = 400000;

   round_robin_task_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_word(rsp_word)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end
   end

   // receiver: random stall, check each word taken
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_word(rsp_word);
         rsp_ready <= ($urandom_range(99) >= take_idle);
      end
   end

   // valid drops only for idle cycles, so back-to-back words keep it high
   task send_word(input req_type w);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle) @(posedge clock);
      end
      req_valid <= 1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(w);
      op_seen[w.operation]++;
      sent++;
   endtask

   task send_op(input logic [2:0] op, input logic [15:0] a, input logic [15:0] b,
                input logic [15:0] t);
      req_type w;
      w.operation = op;
      w.task_id = a;
      w.other_id = b;
      w.sleep_ticks = t;
      send_word(w);
   endtask

   // small id pool so lookups hit, with occasional full-range ids
   function logic [15:0] pick_id();
      if ($urandom_range(9) == 0) return 16'($urandom());
      return 16'($urandom_range(12));
   endfunction

   task random_words(input int count);
      logic [2:0] op;
      logic [15:0] t;
      for (int n = 0; n < count; n++) begin
         op = 3'($urandom_range(7));
         if (board.used < 4 && $urandom_range(1)) op = OP_ADD;
         if (board.used > 13 && $urandom_range(1)) op = OP_REMOVE;
         t = ($urandom_range(7) == 0) ? 16'($urandom()) : 16'($urandom_range(3));
         send_op(op, pick_id(), pick_id(), t);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty table, fill to full, special cases
      send_op(OP_PICK, '0, '0, '0);
      send_op(OP_PICK, 16'd5, '0, '0);
      send_op(OP_REMOVE, 16'd5, '0, '0);
      send_op(OP_TICK, '0, '0, '0);
      send_op(OP_ADD, 16'hffff, '0, '0);
      send_op(OP_ADD, 16'h0001, 16'hffff, 16'hffff);
      send_op(OP_ADD, 16'h0001, 16'hffff, '0);
      send_op(OP_WAIT, 16'hffff, 16'h0001, '0);
      send_op(OP_EXIT, 16'h0001, '0, '0);
      send_op(OP_LOOKUP, 16'hffff, '0, '0);
      send_op(OP_SLEEP, 16'h0001, '0, 16'hffff);
      send_op(OP_SLEEP, 16'hffff, '0, '0);
      send_op(OP_TICK, '0, '0, '0);
      send_op(OP_PICK, 16'hffff, '0, '0);
      send_op(OP_PICK, 16'h1234, '0, '0);
      send_op(OP_EXIT, 16'hffff, '0, '0);
      for (int i = 0; i < 15; i++) send_op(OP_ADD, 16'(i + 2), 16'hffff, 16'haaaa);
      send_op(OP_LOOKUP, 16'h5555, '0, '0);
      send_op(OP_REMOVE, 16'hffff, '0, '0);
      random_words(380);
      send_idle = 67;
      take_idle = 32;
      random_words(380);
      send_idle = 0;
      take_idle = 0;
      random_words(380);
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      $display("%0d words sent, %0d responses checked, %0d mismatches", sent,
               board.checked, board.errors);
      $display("ops add %0d rm %0d pick %0d tick %0d look %0d exit %0d sleep %0d wait %0d",
               op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4], op_seen[5],
               op_seen[6], op_seen[7]);
      if (board.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
